>>> design/jfss_pkg.sv
// Package for the JPEG frame size scanner.
// Holds the parser phase type, status codes, marker constants and shared structs.
// No dependencies.
package jfss_pkg;

    // Marker bytes
    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] SOI_CODE      = 8'hD8;
    localparam logic [7:0] SOF_FIRST     = 8'hC0;
    localparam logic [7:0] SOF_LAST      = 8'hCF;
    localparam logic [7:0] DHT_CODE      = 8'hC4;
    localparam logic [7:0] JPG_CODE      = 8'hC8;
    localparam logic [7:0] DAC_CODE      = 8'hCC;
    localparam logic [7:0] SOS_CODE      = 8'hDA;
    localparam logic [7:0] EOI_CODE      = 8'hD9;

    // Smallest legal segment length (the length field itself)
    localparam logic [15:0] MIN_SEG_LEN  = 16'd2;

    typedef enum logic [3:0] {
        PH_MAGIC0,
        PH_MAGIC1,
        PH_SEEK,
        PH_MARKER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_SOF_L1,
        PH_SOF_L2,
        PH_SOF_P,
        PH_SOF_H1,
        PH_SOF_H2,
        PH_SOF_W1,
        PH_SOF_W2,
        PH_SOF_NC,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_BADMAGIC  = 3'd1,
        ST_STRAY     = 3'd2,
        ST_SCANFIRST = 3'd3,
        ST_BADLEN    = 3'd4,
        ST_TRUNC     = 3'd5
    } status_t;

    // One input request
    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_stream;
    } item_t;

    // One result request
    typedef struct packed {
        status_t     status;
        logic [15:0] frame_height;
        logic [15:0] frame_width;
    } result_t;

    // Parser status toward the top level
    typedef struct packed {
        logic   emit;
        phase_t phase;
    } parse_ctl_t;

endpackage

>>> design/jfss_in_reg.sv
// Input register stage of the JPEG frame size scanner.
// Holds one accepted byte request until the parser consumes it. Uses jfss_pkg.
module jfss_in_reg
    import jfss_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  valid,
    input  item_t item,
    output logic  stall,
    input  logic  take,
    output logic  stage_valid,
    output item_t stage_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // Accept when empty or when the held request leaves this cycle
    assign stall = valid_reg && !take;
    assign load  = valid && !stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

>>> design/jfss_parser.sv
// Marker walker of the JPEG frame size scanner: phase state and result logic.
// Updates its state when the top level fires it. Uses jfss_pkg.
module jfss_parser
    import jfss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  item_t      item,
    output parse_ctl_t ctl,
    output result_t    result
);

    phase_t      phase_reg, phase_next;
    logic [15:0] skip_count_reg, skip_count_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] width_reg, width_next;
    logic        stray_reg, stray_next;

    logic [7:0]  b;
    logic [15:0] seg_len;
    logic        frame_marker;
    logic        scan_or_end;
    logic        emit;

    assign b       = item.byte_value;
    assign seg_len = {length_high_reg, b};

    // Start-of-frame codes: C0..CF without DHT, JPG and DAC
    always_comb
    begin
        frame_marker = (b inside {[SOF_FIRST:SOF_LAST]})
                       && !(b inside {DHT_CODE, JPG_CODE, DAC_CODE});
        scan_or_end  = (b == SOS_CODE) || (b == EOI_CODE);
    end

    // Next state
    always_comb
    begin
        phase_next       = phase_reg;
        skip_count_next  = skip_count_reg;
        length_high_next = length_high_reg;
        height_next      = height_reg;
        width_next       = width_reg;
        stray_next       = stray_reg;
        if (item.end_of_stream)
        begin
            // Re-arm: everything back to reset values
            phase_next       = PH_MAGIC0;
            skip_count_next  = '0;
            length_high_next = '0;
            height_next      = '0;
            width_next       = '0;
            stray_next       = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_MAGIC0: phase_next = (b == MARKER_PREFIX) ? PH_MAGIC1 : PH_DONE;
                PH_MAGIC1: phase_next = (b == SOI_CODE) ? PH_SEEK : PH_DONE;
                PH_SEEK:
                begin
                    if (b == MARKER_PREFIX)
                    begin
                        phase_next = PH_MARKER;
                    end
                    else
                    begin
                        stray_next = 1'b1;
                    end
                end
                PH_MARKER:
                begin
                    // Fill bytes keep us here
                    if (b != MARKER_PREFIX)
                    begin
                        if (stray_reg || (!frame_marker && scan_or_end))
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (frame_marker)
                        begin
                            phase_next = PH_SOF_L1;
                        end
                        else
                        begin
                            phase_next = PH_LEN_HI;
                        end
                    end
                end
                PH_LEN_HI:
                begin
                    length_high_next = b;
                    phase_next       = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    if (seg_len < MIN_SEG_LEN)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        skip_count_next = seg_len - MIN_SEG_LEN;
                        phase_next = (seg_len == MIN_SEG_LEN) ? PH_SEEK : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_count_next = skip_count_reg - 16'd1;
                    if (skip_count_reg == 16'd1)
                    begin
                        phase_next = PH_SEEK;
                    end
                end
                PH_SOF_L1: phase_next = PH_SOF_L2;
                PH_SOF_L2: phase_next = PH_SOF_P;
                PH_SOF_P:  phase_next = PH_SOF_H1;
                PH_SOF_H1:
                begin
                    height_next = {b, 8'h00};
                    phase_next  = PH_SOF_H2;
                end
                PH_SOF_H2:
                begin
                    height_next = {height_reg[15:8], b};
                    phase_next  = PH_SOF_W1;
                end
                PH_SOF_W1:
                begin
                    width_next = {b, 8'h00};
                    phase_next = PH_SOF_W2;
                end
                PH_SOF_W2:
                begin
                    width_next = {width_reg[15:8], b};
                    phase_next = PH_SOF_NC;
                end
                PH_SOF_NC: phase_next = PH_DONE;
                PH_DONE:   phase_next = PH_DONE;
                default:   phase_next = PH_DONE;
            endcase
        end
    end

    // Result for the current request
    always_comb
    begin
        emit   = 1'b0;
        result = '{status: ST_FOUND, frame_height: 16'h0000, frame_width: 16'h0000};
        if (item.end_of_stream)
        begin
            emit = (phase_reg != PH_DONE);
            result.status = ((phase_reg == PH_MAGIC0) || (phase_reg == PH_MAGIC1))
                            ? ST_BADMAGIC : ST_TRUNC;
        end
        else
        begin
            case (phase_reg)
                PH_MAGIC0:
                begin
                    emit          = (b != MARKER_PREFIX);
                    result.status = ST_BADMAGIC;
                end
                PH_MAGIC1:
                begin
                    emit          = (b != SOI_CODE);
                    result.status = ST_BADMAGIC;
                end
                PH_MARKER:
                begin
                    emit = (b != MARKER_PREFIX) && (stray_reg || (!frame_marker && scan_or_end));
                    result.status = stray_reg ? ST_STRAY : ST_SCANFIRST;
                end
                PH_LEN_LO:
                begin
                    emit          = (seg_len < MIN_SEG_LEN);
                    result.status = ST_BADLEN;
                end
                PH_SOF_NC:
                begin
                    emit                = 1'b1;
                    result.status       = ST_FOUND;
                    result.frame_height = height_reg;
                    result.frame_width  = width_reg;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_MAGIC0;
            skip_count_reg  <= '0;
            length_high_reg <= '0;
            height_reg      <= '0;
            width_reg       <= '0;
            stray_reg       <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            skip_count_reg  <= skip_count_next;
            length_high_reg <= length_high_next;
            height_reg      <= height_next;
            width_reg       <= width_next;
            stray_reg       <= stray_next;
        end
    end

    assign ctl.emit  = emit;
    assign ctl.phase = phase_reg;

endmodule

>>> design/jfss_out_reg.sv
// Result register of the JPEG frame size scanner.
// Holds one result request until the receiver takes it. Uses jfss_pkg.
module jfss_out_reg
    import jfss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    output logic    ready,
    output logic    valid,
    input  logic    stall,
    output result_t result_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Free when empty or when the held result leaves this cycle
    assign ready = !valid_reg || !stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign valid      = valid_reg;
    assign result_out = result_reg;

endmodule

>>> design/jpeg_frame_size_scanner.sv
// Top level of the JPEG frame size scanner: input register, marker walker, result register.
// Uses jfss_pkg, jfss_in_reg, jfss_parser and jfss_out_reg.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------
//  byte in | item_valid / item_stall    | byte_value[7:0], end_of_stream
//  result  | result_valid / result_stall| status[2:0], frame_height, frame_width
//
// One byte request per cycle while item_stall is low; the walker updates its phase once per byte.
// A byte is held in the input register, and its result is then held in the result register.
// rst_n clears the phase to "expect first magic byte" and empties both registers.
// A stalled result only backs up the input once a second result is waiting behind it;
// bytes that give no result keep flowing while the result register is held.
module jpeg_frame_size_scanner
    import jfss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  byte_value,
    input  logic        end_of_stream,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [15:0] frame_height,
    output logic [15:0] frame_width
);

    item_t      in_item;
    item_t      stage_item;
    logic       stage_valid;
    logic       take;
    logic       out_ready;
    parse_ctl_t ctl;
    result_t    parse_result;
    result_t    out_result;

    assign in_item = '{byte_value: byte_value, end_of_stream: end_of_stream};

    // The held byte goes through unless its result has nowhere to go
    assign take = stage_valid && (!ctl.emit || out_ready);

    jfss_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (item_valid),
        .item        (in_item),
        .stall       (item_stall),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    jfss_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (take),
        .item   (stage_item),
        .ctl    (ctl),
        .result (parse_result)
    );

    jfss_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take && ctl.emit),
        .result_in  (parse_result),
        .ready      (out_ready),
        .valid      (result_valid),
        .stall      (result_stall),
        .result_out (out_result)
    );

    assign status       = out_result.status;
    assign frame_height = out_result.frame_height;
    assign frame_width  = out_result.frame_width;

    // Input only backs up while a byte is held
    a_stall_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> stage_valid)
        else $error("input stalled with empty input register");

    // Error results carry no dimensions
    a_error_zero_dims: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != ST_FOUND)) |->
            ((frame_height == 16'h0000) && (frame_width == 16'h0000)))
        else $error("error result with nonzero dimensions");

    // A result from a byte parks the walker until end of stream
    a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && ctl.emit && !stage_item.end_of_stream) |=> (ctl.phase == PH_DONE))
        else $error("walker not parked after result");

    // End of stream always re-arms
    a_eos_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (take && stage_item.end_of_stream) |=> (ctl.phase == PH_MAGIC0))
        else $error("end of stream did not re-arm");

endmodule
